FILE: sv/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants
// Sequencer states, codes and default sizes of the rotation align block.
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int DEF_MAX_PAIRS  = 4096;
  localparam int DEF_COORD_BITS = 24;

  localparam int PT_W   = 24;   // coordinate width on the bus
  localparam int ROT_W  = 18;   // Q1.16 rotation width
  localparam int MUL_W  = 33;   // shared multiplier operand width
  localparam int SUM_W  = 64;
  localparam int NUM_W  = 48;   // divider numerator width
  localparam int ROOT_W = 32;
  localparam int QUO_W  = 17;

  localparam logic signed [ROT_W-1:0] COS_ONE = 18'sd65536;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_APPLY = 1'b1;
  localparam logic KIND_ROT  = 1'b0;
  localparam logic KIND_PT   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_LAST, ST_NORM,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_ROOT, ST_DIVC, ST_DIVCW, ST_DIVS, ST_DIVSW,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_EMIT
  } state_t;

endpackage

FILE: sv/rra_mul.sv
// ----------------------------------------------------------------------------
// rra_mul: shared registered multiplier
// One signed multiply per cycle with the product registered.
// ----------------------------------------------------------------------------
module rra_mul (
  input  logic                              clk,
  input  logic signed [rra_pkg::MUL_W-1:0]  a,
  input  logic signed [rra_pkg::MUL_W-1:0]  b,
  output logic signed [rra_pkg::SUM_W-1:0]  p
);
  import rra_pkg::*;

  logic signed [2*MUL_W-1:0] full;

  assign full = a * b;

  // Register the product
  always_ff @(posedge clk) begin
    p <= full[SUM_W-1:0];
  end

endmodule

FILE: sv/rra_sqrt.sv
// ----------------------------------------------------------------------------
// rra_sqrt: iterative integer square root
// One result bit per pair of radicand bits, one step a cycle, 32 steps.
// ----------------------------------------------------------------------------
module rra_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [62:0]                 n,
  output logic                        done,
  output logic [rra_pkg::ROOT_W-1:0]  root
);
  import rra_pkg::*;

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Advance one root step
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, n};
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

FILE: sv/rra_div.sv
// ----------------------------------------------------------------------------
// rra_div: restoring divider
// One quotient bit a cycle over the 48-bit numerator; quotient below 2^17.
// ----------------------------------------------------------------------------
module rra_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rra_pkg::NUM_W-1:0]   num,
  input  logic [rra_pkg::ROOT_W-1:0]  den,
  output logic                        done,
  output logic [rra_pkg::QUO_W-1:0]   quo
);
  import rra_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_sh;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W-1:0] den_q;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [ROOT_W:0]   rem2;
  logic [ROOT_W:0]   diff;

  assign rem2 = {rem, num_sh[NUM_W-1]};
  assign diff = rem2 - {1'b0, den_q};

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Advance one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_q  <= den;
      rem    <= '0;
      quo    <= '0;
      cnt    <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      cnt    <= cnt + 1'b1;
      if (!diff[ROOT_W]) begin
        rem <= diff[ROOT_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem2[ROOT_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/rigid_rotation_align_average.sv
// ----------------------------------------------------------------------------
// rigid_rotation_align_average: least-squares 2D rotation align and average
// Accumulates cross and dot sums of point pairs, solves the rotation on the
// last pair, then rotates moving points and averages them with the reference.
//
//   channel   dir  tdata (low bit up)                          side bits
//   s_*       in   ref_x, ref_y, mov_x, mov_y (96)              tuser=cmd, tlast=is_last
//   m_*       out  avg_x, avg_y, rot_cos, rot_sin,              tuser=kind
//                  degenerate, overflowed, 2 zero bits (88)
//
// An accumulate pair passes states A0 to A4 and then LAST, an apply pair P0 to
// P5, and a pair dropped at the limit goes straight to LAST. A last pair also
// normalises (33 shifts at most), takes the square root and runs the two
// divisions, all on one multiplier, one root unit and one divider.
// Reset is synchronous, clears the sums and sets the held rotation to the identity. A stalled
// result waits in the output register; the next item is taken meanwhile, and
// its result waits until that register is free.
// ----------------------------------------------------------------------------
module rigid_rotation_align_average #(
  parameter int MAX_PAIRS  = rra_pkg::DEF_MAX_PAIRS,
  parameter int COORD_BITS = rra_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // ref_x, ref_y, mov_x, mov_y
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // avg_x, avg_y, rot_cos, rot_sin, degenerate, overflowed
  output logic        m_tuser    // kind
);
  import rra_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam logic signed [SUM_W-1:0] PT_HI = SUM_W'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [SUM_W-1:0] PT_LO = -PT_HI - 1;
  localparam logic signed [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  state_t state, state_next;

  logic signed [PT_W-1:0]  rx, ry, mx, my;
  logic                    last_q;
  logic signed [SUM_W-1:0] sum_cross, sum_dot;
  logic [CNT_W-1:0]        pair_count;
  logic                    overflow_seen;
  logic signed [ROT_W-1:0] cos_held, sin_held;
  logic [SUM_W-1:0]        mc, md;
  logic                    neg_c, neg_d;
  logic signed [SUM_W-1:0] t, vx, vy;
  logic [ROOT_W-1:0]       r;

  logic                    res_kind, res_degen, res_ovf;
  logic signed [PT_W-1:0]  res_ax, res_ay;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [SUM_W-1:0] p;
  logic                    sq_start, sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    dv_start, dv_done;
  logic [NUM_W-1:0]        dv_num;
  logic [QUO_W-1:0]        dv_quo;

  logic                    take, out_free;
  logic signed [SUM_W:0]   add_x, add_s;
  logic signed [SUM_W-1:0] term, rnd_x, rnd_y;

  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Shared units
  rra_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  rra_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .n(63'(t + p)),
    .done(sq_done), .root(sq_root)
  );

  rra_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(r),
    .done(dv_done), .quo(dv_quo)
  );

  assign sq_start = (state == ST_SQ2);
  assign dv_start = (state == ST_DIVC) || (state == ST_DIVS);
  assign dv_num   = (state == ST_DIVC) ? NUM_W'({md[30:0], 16'b0}) + NUM_W'(r >> 1)
                                       : NUM_W'({mc[30:0], 16'b0}) + NUM_W'(r >> 1);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_A0:  begin mul_a = MUL_W'(mx); mul_b = MUL_W'(ry); end
      ST_A1:  begin mul_a = MUL_W'(my); mul_b = MUL_W'(rx); end
      ST_A2:  begin mul_a = MUL_W'(mx); mul_b = MUL_W'(rx); end
      ST_A3:  begin mul_a = MUL_W'(my); mul_b = MUL_W'(ry); end
      ST_SQ0: begin mul_a = {2'b0, mc[30:0]}; mul_b = {2'b0, mc[30:0]}; end
      ST_SQ1: begin mul_a = {2'b0, md[30:0]}; mul_b = {2'b0, md[30:0]}; end
      ST_P0:  begin mul_a = MUL_W'(mx); mul_b = MUL_W'(cos_held); end
      ST_P1:  begin mul_a = MUL_W'(my); mul_b = MUL_W'(sin_held); end
      ST_P2:  begin mul_a = MUL_W'(mx); mul_b = MUL_W'(sin_held); end
      ST_P3:  begin mul_a = MUL_W'(my); mul_b = MUL_W'(cos_held); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Form the saturating sum addend and the rounded averages
  assign term  = (state == ST_A2) ? (t - p) : (t + p);
  assign add_s = (state == ST_A2) ? {sum_cross[SUM_W-1], sum_cross}
                                  : {sum_dot[SUM_W-1], sum_dot};
  assign add_x = add_s + {term[SUM_W-1], term};
  assign rnd_x = (vx + SUM_W'(65536)) >>> 17;
  assign rnd_y = (vy + SUM_W'(65536)) >>> 17;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the work of one transaction
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (s_tuser == CMD_APPLY) begin
            state_next = ST_P0;
          end else if (pair_count >= CNT_W'(MAX_PAIRS)) begin
            state_next = ST_LAST;
          end else begin
            state_next = ST_A0;
          end
        end
      end
      ST_A0:  state_next = ST_A1;
      ST_A1:  state_next = ST_A2;
      ST_A2:  state_next = ST_A3;
      ST_A3:  state_next = ST_A4;
      ST_A4:  state_next = ST_LAST;
      ST_LAST: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (sum_cross == '0 && sum_dot == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (((mc | md) >> 31) == '0) begin
          state_next = ST_SQ0;
        end
      end
      ST_SQ0:  state_next = ST_SQ1;
      ST_SQ1:  state_next = ST_SQ2;
      ST_SQ2:  state_next = ST_ROOT;
      ST_ROOT: if (sq_done) state_next = ST_DIVC;
      ST_DIVC: state_next = ST_DIVCW;
      ST_DIVCW: if (dv_done) state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVSW;
      ST_DIVSW: if (dv_done) state_next = ST_EMIT;
      ST_P0:   state_next = ST_P1;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_P4;
      ST_P4:   state_next = ST_P5;
      ST_P5:   state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (take) begin
      rx     <= s_tdata[23:0];
      ry     <= s_tdata[47:24];
      mx     <= s_tdata[71:48];
      my     <= s_tdata[95:72];
      last_q <= s_tlast;
    end
  end

  // Advance sums, count and held rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_cross     <= '0;
      sum_dot       <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
      cos_held      <= COS_ONE;
      sin_held      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take && s_tuser == CMD_ACCUM && pair_count >= CNT_W'(MAX_PAIRS)) begin
            overflow_seen <= 1'b1;
          end
        end
        ST_A2: begin
          if (add_x[SUM_W] != add_x[SUM_W-1]) begin
            sum_cross     <= add_x[SUM_W] ? S_MIN : S_MAX;
            overflow_seen <= 1'b1;
          end else begin
            sum_cross <= add_x[SUM_W-1:0];
          end
        end
        ST_A4: begin
          if (add_x[SUM_W] != add_x[SUM_W-1]) begin
            sum_dot       <= add_x[SUM_W] ? S_MIN : S_MAX;
            overflow_seen <= 1'b1;
          end else begin
            sum_dot <= add_x[SUM_W-1:0];
          end
          pair_count <= pair_count + 1'b1;
        end
        ST_LAST: begin
          if (last_q) begin
            sum_cross     <= '0;
            sum_dot       <= '0;
            pair_count    <= '0;
            overflow_seen <= 1'b0;
            if (sum_cross == '0 && sum_dot == '0) begin
              cos_held <= COS_ONE;
              sin_held <= '0;
            end
          end
        end
        ST_DIVCW: begin
          if (dv_done) begin
            cos_held <= neg_d ? -ROT_W'(dv_quo) : ROT_W'(dv_quo);
          end
        end
        ST_DIVSW: begin
          if (dv_done) begin
            sin_held <= neg_c ? -ROT_W'(dv_quo) : ROT_W'(dv_quo);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Work the solve and apply datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_A1, ST_A3, ST_P1, ST_SQ1: t <= p;
      ST_P2: t <= t - p;
      ST_P3: begin
        vx <= t + {{24{rx[PT_W-1]}}, rx, 16'b0};
        t  <= p;
      end
      ST_P4: vy <= t + p + {{24{ry[PT_W-1]}}, ry, 16'b0};
      ST_LAST: begin
        neg_c     <= sum_cross[SUM_W-1];
        neg_d     <= sum_dot[SUM_W-1];
        mc        <= sum_cross[SUM_W-1] ? -sum_cross : sum_cross;
        md        <= sum_dot[SUM_W-1] ? -sum_dot : sum_dot;
        res_kind  <= KIND_ROT;
        res_degen <= (sum_cross == '0 && sum_dot == '0);
        res_ovf   <= overflow_seen;
        res_ax    <= '0;
        res_ay    <= '0;
      end
      ST_NORM: begin
        if (((mc | md) >> 31) != '0) begin
          mc <= mc >> 1;
          md <= md >> 1;
        end
      end
      ST_ROOT: if (sq_done) r <= sq_root;
      ST_P5: begin
        res_kind  <= KIND_PT;
        res_degen <= 1'b0;
        res_ovf   <= (rnd_x > PT_HI) || (rnd_x < PT_LO) ||
                     (rnd_y > PT_HI) || (rnd_y < PT_LO);
        res_ax    <= (rnd_x > PT_HI) ? PT_HI[PT_W-1:0] :
                     (rnd_x < PT_LO) ? PT_LO[PT_W-1:0] : rnd_x[PT_W-1:0];
        res_ay    <= (rnd_y > PT_HI) ? PT_HI[PT_W-1:0] :
                     (rnd_y < PT_LO) ? PT_LO[PT_W-1:0] : rnd_y[PT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Hold the output register until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tuser <= res_kind;
      m_tdata <= {2'b00, res_ovf, res_degen, sin_held, cos_held, res_ay, res_ax};
    end
  end

endmodule

FILE: sv/rra_check.sv
// ----------------------------------------------------------------------------
// rra_check: port checker for the rotation align block
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module rra_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tuser
);
  import rra_pkg::*;

  // An accepted transaction keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while the previous transaction is at work");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result dropped or changed");

  // Rotation results carry zero averages
  a_rot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ROT |-> m_tdata[47:0] == 48'b0)
    else $error("rotation result with non-zero average");

  // A degenerate solve gives the identity, never on a point result
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[84] |->
      m_tuser == KIND_ROT && m_tdata[65:48] == COS_ONE && m_tdata[83:66] == 18'b0)
    else $error("degenerate result without identity rotation");

endmodule

bind rigid_rotation_align_average rra_check u_rra_check (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: tb/sv/rigid_rotation_align_average_tb.sv
// ----------------------------------------------------------------------------
// rigid_rotation_align_average_tb: self-checking bench for the rotation align
// Streams accumulate runs and apply points into the block with random gaps
// and result back-pressure. A scoreboard class predicts each result from its
// own copy of the sums and the held rotation and checks every field in order.
// ----------------------------------------------------------------------------
module rigid_rotation_align_average_tb;
  import rra_pkg::*;

  localparam int LIMIT_PAIRS = 4096;
  localparam int WATCHDOG    = 20000;

  typedef struct {
    logic                    kind;
    logic signed [PT_W-1:0]  ax;
    logic signed [PT_W-1:0]  ay;
    logic signed [ROT_W-1:0] rc;
    logic signed [ROT_W-1:0] rs;
    logic                    degen;
    logic                    ovf;
  } align_out_t;

  // Predicts the block: running sums, pair count and the held rotation
  class align_scoreboard;
    longint     sum_cross, sum_dot;
    int         pairs;
    bit         ovf_seen;
    longint     cos_q, sin_q;
    align_out_t expected_out[$];
    int         errors, n_rot, n_pt, n_degen, n_ovf;

    function new();
      sum_cross = 0; sum_dot = 0; pairs = 0; ovf_seen = 0;
      cos_q = 65536; sin_q = 0; errors = 0;
      n_rot = 0; n_pt = 0; n_degen = 0; n_ovf = 0;
    endfunction

    function longint add_clamped(longint a, longint b, inout bit sat);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        sat = 1;
        s = a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      end
      return s;
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint unit_part(longint unsigned m, longint unsigned r, bit neg);
      longint q;
      q = longint'((m * 65536 + (r >> 1)) / r);
      return neg ? -q : q;
    endfunction

    function longint half_sum(longint v, inout bit sat);
      longint a;
      a = (v + 65536) >>> 17;
      if (a > 8388607) begin a = 8388607; sat = 1; end
      if (a < -8388608) begin a = -8388608; sat = 1; end
      return a;
    endfunction

    // Note one accepted input transaction and queue its result, if any
    function void note_pair(logic cmd, logic [95:0] d, logic last);
      longint rx, ry, mx, my, vx, vy;
      longint unsigned mc, md, r;
      bit sat;
      align_out_t e;
      rx = longint'($signed(d[23:0]));  ry = longint'($signed(d[47:24]));
      mx = longint'($signed(d[71:48])); my = longint'($signed(d[95:72]));
      e = '{default: '0};
      sat = 0;
      if (cmd == CMD_ACCUM) begin
        if (pairs >= LIMIT_PAIRS) begin
          ovf_seen = 1;
        end else begin
          sum_cross = add_clamped(sum_cross, mx * ry - my * rx, sat);
          sum_dot   = add_clamped(sum_dot, mx * rx + my * ry, sat);
          if (sat) ovf_seen = 1;
          pairs++;
        end
        if (!last) return;
        e.kind = KIND_ROT;
        if (sum_cross == 0 && sum_dot == 0) begin
          cos_q = 65536; sin_q = 0; e.degen = 1;
        end else begin
          mc = sum_cross < 0 ? -sum_cross : sum_cross;
          md = sum_dot < 0 ? -sum_dot : sum_dot;
          while (((mc | md) >> 31) != 0) begin
            mc >>= 1; md >>= 1;
          end
          r = int_root(mc * mc + md * md);
          cos_q = unit_part(md, r, sum_dot < 0);
          sin_q = unit_part(mc, r, sum_cross < 0);
        end
        e.ovf = ovf_seen;
        sum_cross = 0; sum_dot = 0; pairs = 0; ovf_seen = 0;
      end else begin
        vx = mx * cos_q - my * sin_q + rx * 65536;
        vy = mx * sin_q + my * cos_q + ry * 65536;
        e.kind = KIND_PT;
        e.ax = half_sum(vx, sat);
        e.ay = half_sum(vy, sat);
        e.ovf = sat;
      end
      e.rc = cos_q[ROT_W-1:0];
      e.rs = sin_q[ROT_W-1:0];
      expected_out.push_back(e);
    endfunction

    function void field_cmp(string nm, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, nm, exp_v, act_v);
      end
    endfunction

    // Check one accepted result transaction against the oldest expectation
    function void check_out(logic kind, logic [87:0] d);
      align_out_t e;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual kind %0d data %h",
                 $time, kind, d);
        return;
      end
      e = expected_out.pop_front();
      if (e.kind == KIND_ROT) n_rot++; else n_pt++;
      if (e.degen) n_degen++;
      if (e.ovf) n_ovf++;
      field_cmp("kind", e.kind, kind);
      field_cmp("avg_x", e.ax, $signed(d[23:0]));
      field_cmp("avg_y", e.ay, $signed(d[47:24]));
      field_cmp("rot_cos", e.rc, $signed(d[65:48]));
      field_cmp("rot_sin", e.rs, $signed(d[83:66]));
      field_cmp("degenerate", e.degen, d[84]);
      field_cmp("overflowed", e.ovf, d[85]);
      field_cmp("pad", 0, d[87:86]);
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tuser = 0, s_tlast = 0;
  logic [95:0] s_tdata = '0;
  logic        s_tready, m_tvalid, m_tuser;
  logic        m_tready = 0;
  logic [87:0] m_tdata;

  align_scoreboard sb = new();
  bit in_taken = 0, steady = 0;
  int idle_cycles = 0, n_items = 0;

  rigid_rotation_align_average dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        sb.note_pair(s_tuser, s_tdata, s_tlast);
        in_taken = 1;
        idle_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        sb.check_out(m_tuser, m_tdata);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk)
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);

  function automatic logic [23:0] pick_coord();
    case ($urandom_range(9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h000000;
      3, 4, 5: return 24'($signed($urandom_range(16383)) - 8192);
      default: return 24'($urandom);
    endcase
  endfunction

  // Drive one transaction from a falling edge and hold it until taken;
  // valid stays high afterwards until the caller drives again or drops it
  task automatic send(logic cmd, logic last, logic [23:0] rx, logic [23:0] ry,
                      logic [23:0] mx, logic [23:0] my);
    if (!steady && $urandom_range(99) < 14) begin
      s_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tlast  <= last;
    s_tdata  <= {my, mx, ry, rx};
    in_taken = 0;
    do @(negedge clk); while (!in_taken);
    n_items++;
  endtask

  task automatic send_random(logic cmd, logic last);
    send(cmd, last, pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endtask

  initial begin
    int run_len;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: apply before any solve, empty solve, extremes, cancelling pairs
    send(CMD_APPLY, 1, 24'h000100, 24'hfff000, 24'h001000, 24'h000200);
    send(CMD_APPLY, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send(CMD_APPLY, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send(CMD_ACCUM, 1, 24'h0, 24'h0, 24'h0, 24'h0);
    send(CMD_ACCUM, 0, 24'h001000, 24'h0, 24'h001000, 24'h0);
    send(CMD_ACCUM, 1, 24'hfff000, 24'h0, 24'h001000, 24'h0);
    send(CMD_ACCUM, 0, 24'h001000, 24'h0, 24'h0, 24'h001000);
    send(CMD_ACCUM, 1, 24'h002000, 24'h001000, 24'h001000, 24'h002000);
    send(CMD_APPLY, 0, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000);
    send(CMD_APPLY, 0, 24'h000001, 24'hffffff, 24'h000003, 24'hfffffd);
    send(CMD_ACCUM, 1, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send(CMD_ACCUM, 1, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
    send(CMD_APPLY, 1, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff);
    send(CMD_ACCUM, 1, 24'h0, 24'h0, 24'h000000, 24'hfff000);
    send(CMD_APPLY, 0, 24'h123456, 24'hedcba9, 24'h654321, 24'h9abcde);

    // Pause until the block has drained
    s_tvalid <= 0;
    wait (sb.expected_out.size() == 0);
    @(negedge clk);

    // Long run with no idling on either side
    steady = 1;
    for (int i = 0; i < 200; i++)
      send_random(CMD_ACCUM, i == 199);
    send_random(CMD_APPLY, 0);
    steady = 0;

    // Random: mostly well-formed runs followed by applies, some noise
    while (n_items < 900) begin
      if ($urandom_range(9) == 0) begin
        send_random($urandom_range(1), $urandom_range(1));
      end else begin
        run_len = $urandom_range(6, 1);
        for (int i = 0; i < run_len; i++)
          send_random(CMD_ACCUM, i == run_len - 1);
        repeat ($urandom_range(5)) send_random(CMD_APPLY, $urandom_range(1));
      end
    end

    s_tvalid <= 0;
    wait (sb.expected_out.size() == 0);
    repeat (300) @(negedge clk);
    $display("covered %0d inputs: %0d rotation and %0d point results checked",
             n_items, sb.n_rot, sb.n_pt);
    $display("degenerate solves %0d, overflow flags %0d, one long run without gaps",
             sb.n_degen, sb.n_ovf);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
